### rtl/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time iteration block.
// Used by the top level, its port checker and the bench; depends on nothing else.
`timescale 1ns / 1ps

package mbe_pkg;

  // Width and reset value of the iteration limit register
  localparam int unsigned LIMIT_BITS = 16;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd256;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_FIN   = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Which product the shared multiplier is working on
  typedef enum logic [1:0] {
    OP_RR = 2'd0,  // re * re
    OP_II = 2'd1,  // im * im
    OP_RI = 2'd2   // re * im
  } op_t;

endpackage

### rtl/mandelbrot_escape_iteration.sv
// Top level of the Mandelbrot escape-time iteration block: sequencer, shared
// multiplier, saturating fixed-point update and escape test. Imports mbe_pkg.
`timescale 1ns / 1ps

// One pixel per input transfer: z starts at (start_re, start_im) and is
// replaced by z*z + c up to iteration_limit times, stopping early once the
// squared magnitude of the z just squared reaches 4.0. The result carries the
// step count (0 if the point never escaped) and the last z. All values are
// signed fixed point with FRACTION_BITS fraction bits; products round towards
// minus infinity and every product and sum saturates. The block works on one
// pixel at a time and holds in_tready low until the result has been taken.
// All three products of a step go through one shared multiplier of at most
// 32 x 32 bits for WORD_BITS up to 64; each multiplication sums P partial
// products (1 for WORD_BITS up to 32, 4 above). A step passes through the
// check, the partial products and a finishing state for each of the three
// products, then the update. The block is ready again in the cycle after
// the result transfer. The iteration limit may be written at any time the
// block is idle; cfg_tready is always high.
module mandelbrot_escape_iteration
  import mbe_pkg::*;
#(
  parameter int unsigned WORD_BITS     = 32,
  parameter int unsigned FRACTION_BITS = 25,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // input channel
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // start_re, start_im, const_re, const_im (lowest bits first)
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]              in_tdata,
  // result channel
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // escape_count, final_re, final_im (lowest bits first)
  output logic [((COUNT_BITS+2*WORD_BITS+7)/8)*8-1:0]   out_tdata,
  // configuration channel
  input  logic                                          cfg_tvalid,
  output logic                                          cfg_tready,
  // iteration_limit
  input  logic [LIMIT_BITS-1:0]                         cfg_tdata
);

  localparam int unsigned W           = WORD_BITS;
  localparam int unsigned F           = FRACTION_BITS;
  localparam int unsigned OUT_TDATA_W = ((COUNT_BITS+2*W+7)/8)*8;
  // multiplier split into limbs of at most 32 bits for WORD_BITS up to 64
  localparam int unsigned NL    = (W > 32) ? 2 : 1;
  localparam int unsigned LIMB  = (W + NL - 1) / NL;
  localparam int unsigned PADW  = NL * LIMB;
  localparam int unsigned ACCW  = 2 * PADW;
  localparam int unsigned NPP   = NL * NL;
  localparam int unsigned SUMW  = (W + 1 > F + 3) ? W + 1 : F + 3;

  localparam logic [W-1:0]    W_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]    W_MIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [ACCW-1:0] POS_LIM = {{(ACCW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [ACCW-1:0] NEG_LIM = {{(ACCW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [SUMW-1:0] ESC_LIM = {{(SUMW-1){1'b0}}, 1'b1} << (F + 2);
  localparam logic [1:0]      PP_LAST = 2'(NPP - 1);

  // Saturating signed add on W-bit words
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? W_MIN : W_MAX;
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [1:0]            pp_r, pp_nxt;
  logic [LIMIT_BITS-1:0] limit_r;
  logic [LIMIT_BITS-1:0] iter_r, iter_nxt;
  logic                  esc_r, esc_nxt;
  logic [W-1:0]          re_r, re_nxt;
  logic [W-1:0]          im_r, im_nxt;
  logic [W-1:0]          cre_r, cre_nxt;
  logic [W-1:0]          cim_r, cim_nxt;
  logic [W-1:0]          sr_r, sr_nxt;
  logic [W-1:0]          si_r, si_nxt;
  logic [W-1:0]          t_r, t_nxt;
  logic [ACCW-1:0]       acc_r, acc_nxt;

  logic                  in_xfer;
  logic [W-1:0]          opa, opb;
  logic                  prod_neg;
  logic [PADW-1:0]       a_pad, b_pad;
  logic                  ka, kb;
  logic [LIMB-1:0]       a_limb, b_limb;
  logic [ACCW-1:0]       pp_ext;
  logic [ACCW-1:0]       q_floor, q_ceil;
  logic                  rem_nz;
  logic [W-1:0]          fx_res;
  logic [W-1:0]          diff, dbl;
  logic [SUMW-1:0]       mag_sum;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = OUT_TDATA_W'({im_r, re_r,
                                    esc_r ? COUNT_BITS'(iter_r) : {COUNT_BITS{1'b0}}});

  // Select the operands of the current product
  always_comb begin
    unique case (op_r)
      OP_RR: begin
        opa = re_r;
        opb = re_r;
      end
      OP_II: begin
        opa = im_r;
        opb = im_r;
      end
      OP_RI: begin
        opa = re_r;
        opb = im_r;
      end
      default: begin
        opa = re_r;
        opb = im_r;
      end
    endcase
  end

  // Shared multiplier: one limb product per cycle on operand magnitudes
  always_comb begin
    prod_neg = opa[W-1] ^ opb[W-1];
    a_pad    = PADW'(opa[W-1] ? (~opa + 1'b1) : opa);
    b_pad    = PADW'(opb[W-1] ? (~opb + 1'b1) : opb);
    ka       = (NL > 1) && pp_r[0];
    kb       = (NL > 1) && pp_r[1];
    a_limb   = LIMB'(a_pad >> (ka ? LIMB : 0));
    b_limb   = LIMB'(b_pad >> (kb ? LIMB : 0));
    pp_ext   = ACCW'({{LIMB{1'b0}}, a_limb} * {{LIMB{1'b0}}, b_limb});
    pp_ext   = pp_ext << ((ka ? LIMB : 0) + (kb ? LIMB : 0));
  end

  // Scale the exact product by the fraction bits, floor, saturate
  always_comb begin
    q_floor = acc_r >> F;
    rem_nz  = |acc_r[F-1:0];
    q_ceil  = q_floor + ACCW'(rem_nz);
    if (!prod_neg) begin
      fx_res = (q_floor > POS_LIM) ? W_MAX : q_floor[W-1:0];
    end else if (q_ceil > NEG_LIM) begin
      fx_res = W_MIN;
    end else begin
      fx_res = ~q_ceil[W-1:0] + 1'b1;
    end
  end

  // Step update and escape test
  always_comb begin
    diff    = sat_add(sr_r, ~si_r + 1'b1);
    dbl     = sat_add(t_r, t_r);
    mag_sum = SUMW'(sr_r) + SUMW'(si_r);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pp_nxt    = pp_r;
    iter_nxt  = iter_r;
    esc_nxt   = esc_r;
    re_nxt    = re_r;
    im_nxt    = im_r;
    cre_nxt   = cre_r;
    cim_nxt   = cim_r;
    sr_nxt    = sr_r;
    si_nxt    = si_r;
    t_nxt     = t_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          re_nxt    = in_tdata[W-1:0];
          im_nxt    = in_tdata[2*W-1:W];
          cre_nxt   = in_tdata[3*W-1:2*W];
          cim_nxt   = in_tdata[4*W-1:3*W];
          iter_nxt  = '0;
          esc_nxt   = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (iter_r < limit_r && !esc_r) begin
          op_nxt    = OP_RR;
          pp_nxt    = '0;
          acc_nxt   = '0;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_MUL: begin
        acc_nxt = acc_r + pp_ext;
        pp_nxt  = pp_r + 2'd1;
        if (pp_r == PP_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        pp_nxt  = '0;
        acc_nxt = '0;
        unique case (op_r)
          OP_RR: begin
            sr_nxt    = fx_res;
            op_nxt    = OP_II;
            state_nxt = ST_MUL;
          end
          OP_II: begin
            si_nxt    = fx_res;
            op_nxt    = OP_RI;
            state_nxt = ST_MUL;
          end
          default: begin
            t_nxt     = fx_res;
            state_nxt = ST_UPD;
          end
        endcase
      end
      ST_UPD: begin
        re_nxt    = sat_add(diff, cre_r);
        im_nxt    = sat_add(dbl, cim_r);
        esc_nxt   = (mag_sum >= ESC_LIM);
        iter_nxt  = iter_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_tvalid && cfg_tready) begin
        limit_r <= cfg_tdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    pp_r   <= pp_nxt;
    iter_r <= iter_nxt;
    esc_r  <= esc_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    cre_r  <= cre_nxt;
    cim_r  <= cim_nxt;
    sr_r   <= sr_nxt;
    si_r   <= si_nxt;
    t_r    <= t_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

### rtl/mbe_checker.sv
// Port-level checker for the Mandelbrot escape-time iteration block, bound to
// the top level below. Imports mbe_pkg for the shared register width.
`timescale 1ns / 1ps

module mbe_checker
  import mbe_pkg::*;
#(
  parameter int unsigned OUT_TDATA_W = 80
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_tready,
  input logic [LIMIT_BITS-1:0]  cfg_tdata
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Take no new pixel while a result is still on offer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result waits");

  // Drop ready once a pixel is taken
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("block not busy after input transfer");

  // Return to idle straight after the result transfer
  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid && in_tready)
    else $error("block not idle after result transfer");

  // Accept configuration writes at all times
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_tready || $isunknown(cfg_tdata))
    else $error("configuration channel not ready");

endmodule

bind mandelbrot_escape_iteration mbe_checker #(
  .OUT_TDATA_W(OUT_TDATA_W)
) u_mbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_tready (cfg_tready),
  .cfg_tdata  (cfg_tdata)
);

### bench/tb.sv
// Self-checking bench for the Mandelbrot escape-time iteration block.
// Drives pixels through the stream ports and checks each result against a local
// model of the saturating fixed-point iteration. Depends on mbe_pkg and the RTL.
`timescale 1ns / 1ps

module tb
  import mbe_pkg::*;
;

  localparam int unsigned FRAC     = 25;
  localparam int          WATCHDOG = 20000;
  localparam int          N_PHASES = 12;

  localparam logic signed [63:0] W_MAX = 64'sd2147483647;
  localparam logic signed [63:0] W_MIN = -64'sd2147483648;
  localparam logic signed [31:0] FX_ONE = 32'sd33554432;
  localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;

  // One pixel as it travels in in_tdata, start_re in the lowest bits
  typedef struct packed {
    logic signed [31:0] const_im;
    logic signed [31:0] const_re;
    logic signed [31:0] start_im;
    logic signed [31:0] start_re;
  } pixel_t;

  // One result as it travels in out_tdata, escape_count in the lowest bits
  typedef struct packed {
    logic signed [31:0] final_im;
    logic signed [31:0] final_re;
    logic [15:0]        escape_count;
  } pixel_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [127:0]          in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [79:0]           out_tdata;
  logic                  cfg_tvalid;
  logic                  cfg_tready;
  logic [LIMIT_BITS-1:0] cfg_tdata;

  pixel_t                pixel_queue[$];
  pixel_result_t         expected_results[$];
  logic [LIMIT_BITS-1:0] limit_now;
  bit                    in_taken;
  int                    sender_gap_pct;
  int                    receiver_stall_pct;
  int                    quiet_cycles;
  int                    mismatches;
  int                    pixels_accepted;
  int                    escaped_pixels;

  // Settings per phase: iteration limit, sender gap and receiver stall percentages, pixel count
  int phase_limit [N_PHASES] = '{0, 1, 2, 7, 16, 32, 24, 32, 65535, 256, 64, 12};
  int phase_gap   [N_PHASES] = '{0, 48, 0, 13, 0, 48, 0, 13, 0, 13, 0, 48};
  int phase_stall [N_PHASES] = '{0, 0, 48, 13, 0, 0, 48, 13, 0, 13, 48, 0};
  int phase_items [N_PHASES] = '{30, 60, 60, 80, 150, 150, 120, 150, 20, 40, 130, 110};

  mandelbrot_escape_iteration DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a wide value to the signed word range
  function automatic logic signed [31:0] fx_sat(input logic signed [63:0] v);
    if (v > W_MAX) return FX_MAX;
    if (v < W_MIN) return FX_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    return fx_sat(a + b);
  endfunction

  // Exact product, floored by the fraction shift, then saturated
  function automatic logic signed [31:0] fx_product(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] p;
    wa = a;
    wb = b;
    p  = wa * wb;
    return fx_sat(p >>> FRAC);
  endfunction

  // Iterate z = z*z + c for one pixel and form the expected result
  function automatic pixel_result_t escape_time(input pixel_t px,
                                                input logic [LIMIT_BITS-1:0] lim);
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] sr;
    logic signed [31:0] si;
    logic signed [31:0] t;
    logic [63:0]        mag;
    int unsigned        n;
    bit                 escaped;
    pixel_result_t      r;
    zr = px.start_re;
    zi = px.start_im;
    n = 0;
    escaped = 1'b0;
    while (n < lim && !escaped) begin
      sr = fx_product(zr, zr);
      si = fx_product(zi, zi);
      t  = fx_product(zr, zi);
      zr = fx_add(fx_add(sr, 64'sd0 - si), px.const_re);
      zi = fx_add(fx_add(t, t), px.const_im);
      // squares are never negative, so the sum is taken unsigned
      mag = {32'd0, sr} + {32'd0, si};
      escaped = (mag >= (64'd4 << FRAC));
      n++;
    end
    r.escape_count = escaped ? n[15:0] : 16'd0;
    r.final_re = zr;
    r.final_im = zi;
    return r;
  endfunction

  // Uniform value in roughly [-2.0, 2.0]
  function automatic logic signed [31:0] near_set();
    return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
  endfunction

  // Mostly classic pixels (z = 0, c near the set), some with a free start, some noise
  function automatic pixel_t random_pixel(input bit must_escape);
    pixel_t      px;
    int unsigned pick;
    pick = $urandom_range(99);
    px.start_re = '0;
    px.start_im = '0;
    px.const_re = near_set();
    px.const_im = near_set();
    if (pick >= 55 && pick < 80) begin
      px.start_re = near_set();
      px.start_im = near_set();
    end else if (pick >= 80 && pick < 90) begin
      px.const_re = near_set() >>> 1;
      px.const_im = near_set() >>> 1;
    end else if (pick >= 90) begin
      px.start_re = $urandom();
      px.start_im = $urandom();
      px.const_re = $urandom();
      px.const_im = $urandom();
    end
    // magnitude of at least 32 escapes on the first step
    if (must_escape) px.start_re = {pick[0], ~pick[0], 30'($urandom())};
    return px;
  endfunction

  task automatic add_pixel(input logic signed [31:0] sre, input logic signed [31:0] sim,
                           input logic signed [31:0] cre, input logic signed [31:0] cim);
    pixel_t px;
    px.start_re = sre;
    px.start_im = sim;
    px.const_re = cre;
    px.const_im = cim;
    pixel_queue.push_back(px);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    @(negedge clk);
    cfg_tdata  <= value;
    cfg_tvalid <= 1'b1;
    do @(posedge clk); while (!cfg_tready);
    limit_now = value;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  // Hold until every queued pixel has gone in and its result has come back;
  // sample at the rising edge, where the driver's updates have settled
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: present the next pixel once the previous one has been taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          in_tdata  <= pixel_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check on each result transfer
  always @(posedge clk) begin
    pixel_result_t seen;
    pixel_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        want = escape_time(pixel_t'(in_tdata), limit_now);
        expected_results.push_back(want);
        pixels_accepted++;
        if (want.escape_count != 0) escaped_pixels++;
      end
      if (out_tvalid && out_tready) begin
        seen = pixel_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $error("result transfer with no pixel outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (seen.escape_count !== want.escape_count) begin
            $error("escape_count: expected %0d, got %0d", want.escape_count,
                   seen.escape_count);
            mismatches++;
          end
          if (seen.final_re !== want.final_re) begin
            $error("final_re: expected %0d, got %0d", want.final_re, seen.final_re);
            mismatches++;
          end
          if (seen.final_im !== want.final_im) begin
            $error("final_im: expected %0d, got %0d", want.final_im, seen.final_im);
            mismatches++;
          end
        end
      end
      // Watchdog on cycles with no transfer at all
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_tvalid && cfg_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog expired after %0d cycles without a transfer", quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_tvalid          = 1'b0;
    in_tdata           = '0;
    out_tready         = 1'b0;
    cfg_tvalid         = 1'b0;
    cfg_tdata          = '0;
    limit_now          = LIMIT_RESET;
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    quiet_cycles       = 0;
    mismatches         = 0;
    pixels_accepted    = 0;
    escaped_pixels     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset limit: extremes, rounding, escape edges, cycles
    add_pixel(0, 0, 0, 0);
    add_pixel(2 * FX_ONE, 0, 0, 0);
    add_pixel(2 * FX_ONE - 1, 0, 0, 0);
    add_pixel(0, 2 * FX_ONE, 0, 0);
    add_pixel(FX_MAX, FX_MAX, FX_MAX, FX_MAX);
    add_pixel(FX_MIN, FX_MIN, FX_MIN, FX_MIN);
    add_pixel(FX_MIN, FX_MAX, FX_MAX, FX_MIN);
    add_pixel(FX_MAX, FX_MIN, FX_MIN, FX_MAX);
    add_pixel(-1, 1, 0, 0);
    add_pixel(-1, -1, -1, -1);
    add_pixel(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
    add_pixel(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
    add_pixel(0, 0, -2 * FX_ONE, 0);
    add_pixel(0, 0, -2 * FX_ONE, -1);
    add_pixel(0, 0, FX_ONE / 4, 0);
    add_pixel(0, 0, -(3 * FX_ONE) / 4, FX_ONE / 10);
    add_pixel(0, 0, 0, FX_ONE);
    add_pixel(0, 0, -FX_ONE, 0);
    add_pixel(FX_ONE, FX_ONE, FX_ONE / 2, -(FX_ONE / 2));
    add_pixel(FX_ONE / 2, -(FX_ONE / 3), FX_ONE / 5, FX_ONE / 7);
    wait_idle();

    // Random phases over a spread of limits and idling patterns
    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(phase_limit[p][LIMIT_BITS-1:0]);
      sender_gap_pct     = phase_gap[p];
      receiver_stall_pct = phase_stall[p];
      if (phase_limit[p] == 65535) add_pixel(2 * FX_ONE, 0, 0, 0);
      for (int i = 0; i < phase_items[p]; i++)
        pixel_queue.push_back(random_pixel(phase_limit[p] == 65535));
      wait_idle();
    end

    // Let any stray result show before the verdict
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end

    $display("Checked %0d pixels at iteration limits from 0 to 65535 with mixed idling:",
             pixels_accepted);
    $display("  %0d escaped, %0d stayed bounded, %0d mismatches", escaped_pixels,
             pixels_accepted - escaped_pixels, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
